// ===== rtl/tcw_pkg.sv =====
// Shared types, codes and the character mapping for the text console writer.
// Used by tcw_core and text_console_writer; depends on nothing else.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 32;
    localparam int DEF_ROWS    = 16;

    // Field widths of one item
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 9;
    localparam int DATA_W = 8;
    localparam int COL_W  = 5;
    localparam int ROW_W  = 4;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Display codes
    localparam logic [7:0] NEWLINE      = 8'h0A;
    localparam logic [7:0] BLANK_CODE   = 8'h60;
    localparam logic [7:0] HOME_CODE    = 8'h20;
    localparam logic [7:0] UNKNOWN_CODE = 8'h1E;
    localparam logic [7:0] FLIP_MASK    = 8'h40;
    localparam logic [7:0] KEEP_LO      = 8'h20;
    localparam logic [7:0] KEEP_HI      = 8'h3F;
    localparam logic [7:0] SHIFT_LO     = 8'h40;
    localparam logic [7:0] SHIFT_HI     = 8'h5E;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PUT,
        ST_OFF_RD,
        ST_OFF_WR,
        ST_ADV,
        ST_SCROLL,
        ST_ON_RD,
        ST_ON_WR,
        ST_RD,
        ST_RD_WAIT,
        ST_FINISH
    } t_state;

    // Request handed from the top level to the sequencer
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic              video_flip;
        logic [ADDR_W-1:0] cell_addr;
    } t_req;

    // Result handed back
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_res;

    // ASCII to display code, with optional video flip
    function automatic logic [7:0] map_code(input logic [7:0] ch, input logic flip);
        logic [7:0] c;
        if (ch >= KEEP_LO && ch <= KEEP_HI) begin
            c = ch;
        end else if (ch >= SHIFT_LO && ch <= SHIFT_HI) begin
            c = ch - FLIP_MASK;
        end else begin
            c = UNKNOWN_CODE;
        end
        if (flip) begin
            c = c ^ FLIP_MASK;
        end
        return c;
    endfunction

endpackage

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: stream ports and the result register.
// Depends on tcw_pkg and tcw_core.

// Text-mode screen of COLUMNS x ROWS cells (32 x 16 by default) held in one
// synchronous RAM, with the cursor shown by flipping bit 6 of its cell. Items
// are handled one at a time by a sequencer that reads and writes that RAM
// through a single write and a single registered read port. A clear sweeps the
// RAM one cell a cycle. A line advance on the bottom row adds a scroll that
// copies and blanks one cell a cycle. After reset the same clearing sweep runs
// before the first item is taken. The result waits in an output register, so
// the next item may be accepted while it is still pending.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // char_code[7:0], video_flip[8], cell_addr[17:9], zeros
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // read_data[7:0], cursor_col[12:8], cursor_row[16:13], zeros
);

    t_req req;
    t_res res;
    logic core_idle;
    logic core_done;
    logic res_free;
    logic start;

    logic r_out_valid;
    t_res r_out;

    assign req.kind       = i_s_tuser;
    assign req.char_code  = i_s_tdata[7:0];
    assign req.video_flip = i_s_tdata[8];
    assign req.cell_addr  = i_s_tdata[17:9];

    assign o_s_tready = core_idle;
    assign start      = i_s_tvalid & core_idle;
    assign res_free   = !r_out_valid || i_m_tready;

    tcw_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .i_res_free (res_free),
        .o_idle     (core_idle),
        .o_done     (core_done),
        .o_res      (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_done) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.cursor_row, r_out.cursor_col, r_out.read_data};

endmodule

// ===== rtl/tcw_core.sv =====
// Sequencer and screen memory of the text console writer.
// Depends on tcw_pkg for the request/result structs, states and codes.
module tcw_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    input  logic i_res_free,
    output logic o_idle,
    output logic o_done,
    output t_res o_res
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int MEM_AW = $clog2(CELLS);
    localparam int CNT_W  = MEM_AW + 1;
    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);

    localparam logic [CW-1:0]    LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0]    LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] ALL_CELLS = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] KEPT      = CNT_W'(CELLS - COLUMNS);

    // Screen memory
    logic [7:0] r_screen [CELLS];
    logic [7:0] r_rd_data;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic [MEM_AW-1:0] mem_ra;

    t_state r_state, n_state;
    t_req   r_req;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_item, n_item;
    logic [7:0]       r_data, n_data;

    logic [MEM_AW-1:0] cur_addr;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W:0]    src_idx;
    logic              rd_ok;
    logic [31:0]       col_wide;
    logic [31:0]       row_wide;

    assign cur_addr = MEM_AW'(r_row) * MEM_AW'(COLUMNS) + MEM_AW'(r_col);
    assign cnt_m1   = r_cnt - 1'b1;
    assign src_idx  = {1'b0, r_cnt} + (CNT_W + 1)'(COLUMNS);
    assign rd_ok    = 32'(r_req.cell_addr) < 32'(CELLS);
    assign col_wide = 32'(r_col);
    assign row_wide = 32'(r_row);

    // Memory ports: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_screen[mem_ra];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req.kind == KIND_PUT && i_req.char_code == NEWLINE) begin
                        n_state = ST_OFF_RD;
                    end else if (i_req.kind == KIND_PUT) begin
                        n_state = ST_PUT;
                    end else if (i_req.kind == KIND_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_req.kind == KIND_READ) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_CLEAR: begin
                if (r_cnt == LAST_CELL) begin
                    n_state = r_item ? ST_FINISH : ST_IDLE;
                end
            end
            ST_PUT:     n_state = (r_col == LAST_COL) ? ST_ADV : ST_ON_RD;
            ST_OFF_RD:  n_state = ST_OFF_WR;
            ST_OFF_WR:  n_state = ST_ADV;
            ST_ADV:     n_state = (r_row == LAST_ROW) ? ST_SCROLL : ST_ON_RD;
            ST_SCROLL: begin
                if (r_cnt == ALL_CELLS) begin
                    n_state = ST_ON_RD;
                end
            end
            ST_ON_RD:   n_state = ST_ON_WR;
            ST_ON_WR:   n_state = ST_FINISH;
            ST_RD:      n_state = ST_RD_WAIT;
            ST_RD_WAIT: n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Memory controls and datapath updates
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cur_addr;
        mem_wd = BLANK_CODE;
        mem_ra = cur_addr;
        n_col  = r_col;
        n_row  = r_row;
        n_cnt  = r_cnt;
        n_item = r_item;
        n_data = r_data;
        o_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_item = 1'b1;
                    n_cnt  = '0;
                end
            end
            ST_CLEAR: begin
                // Blank every cell; the home cell shows the cursor
                mem_we = 1'b1;
                mem_wa = r_cnt[MEM_AW-1:0];
                mem_wd = (r_cnt == '0) ? HOME_CODE : BLANK_CODE;
                n_cnt  = (r_cnt == LAST_CELL) ? '0 : r_cnt + 1'b1;
                n_col  = '0;
                n_row  = '0;
            end
            ST_PUT: begin
                mem_we = 1'b1;
                mem_wd = map_code(r_req.char_code, r_req.video_flip);
                if (r_col != LAST_COL) begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_OFF_WR, ST_ON_WR: begin
                mem_we = 1'b1;
                mem_wd = r_rd_data ^ FLIP_MASK;
            end
            ST_ADV: begin
                n_col = '0;
                n_cnt = '0;
                if (r_row != LAST_ROW) begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_SCROLL: begin
                // Read one row ahead, write the previous cycle's read; blank the last row
                if (src_idx < (CNT_W + 1)'(CELLS)) begin
                    mem_ra = src_idx[MEM_AW-1:0];
                end
                mem_we = (r_cnt != '0);
                mem_wa = cnt_m1[MEM_AW-1:0];
                mem_wd = (cnt_m1 < KEPT) ? r_rd_data : BLANK_CODE;
                n_cnt  = (r_cnt == ALL_CELLS) ? '0 : r_cnt + 1'b1;
            end
            ST_RD: begin
                mem_ra = MEM_AW'(r_req.cell_addr);
            end
            ST_RD_WAIT: begin
                n_data = rd_ok ? r_rd_data : 8'h00;
            end
            ST_FINISH: begin
                if (i_res_free) begin
                    o_done = 1'b1;
                    n_item = 1'b0;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
            r_item  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            r_item  <= n_item;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_req <= i_req;
        end
        r_data <= n_data;
    end

    assign o_idle            = (r_state == ST_IDLE);
    assign o_res.read_data   = (r_req.kind == KIND_READ) ? r_data : 8'h00;
    assign o_res.cursor_col  = col_wide[COL_W-1:0];
    assign o_res.cursor_row  = row_wide[ROW_W-1:0];

    // Checks
    a_no_write_at_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != ST_IDLE && r_state != ST_FINISH))
        else $error("screen written while no item is in work");
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == ST_IDLE)
        else $error("item started while sequencer busy");
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == ST_IDLE && !r_item))
        else $error("sequencer did not return to idle after a result");
    a_scroll_at_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCROLL |-> (r_row == LAST_ROW && r_col == '0))
        else $error("scroll outside the bottom row");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= LAST_COL && r_row <= LAST_ROW)
        else $error("cursor off screen");

endmodule

// ===== tb/text_console_writer_test.sv =====
// Self-checking testbench for text_console_writer: streams put/clear/read items,
// predicts every result with a local screen shadow and checks each field.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 100ps

module text_console_writer_test;
    import tcw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = COLUMNS * ROWS;

    // Kind code the block leaves unused
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // Idle chance per cycle, in percent
    localparam int IDLE_PCT = 14;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic              video_flip;
        logic [ADDR_W-1:0] cell_addr;
    } t_console_cmd;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_console_status;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // char_code[7:0], video_flip[8], cell_addr[17:9], zeros
    logic [1:0]  i_s_tuser  = '0;   // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;         // read_data[7:0], cursor_col[12:8], cursor_row[16:13], zeros

    t_console_cmd    pending_cmds[$];
    t_console_status awaited_status[$];
    t_console_cmd    next_cmd;

    // Screen shadow and cursor
    logic [7:0]       shadow_screen [CELLS];
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;

    logic cmd_taken      = 1'b0;
    logic calm           = 1'b0;
    int   mismatch_count = 0;

    text_console_writer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic logic [7:0] display_code(logic [7:0] ch, logic flip);
        logic [7:0] code;
        if (ch >= KEEP_LO && ch <= KEEP_HI) begin
            code = ch;
        end else if (ch >= SHIFT_LO && ch <= SHIFT_HI) begin
            code = ch - FLIP_MASK;
        end else begin
            code = UNKNOWN_CODE;
        end
        return flip ? (code ^ FLIP_MASK) : code;
    endfunction

    // Cursor shown by flipping bit 6 of its cell
    function automatic void toggle_cursor();
        shadow_screen[{cur_row, cur_col}] ^= FLIP_MASK;
    endfunction

    // Column 0 of the next row; on the bottom row scroll up and blank it
    function automatic void advance_row();
        cur_col = '0;
        if (cur_row == ROW_W'(ROWS - 1)) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                shadow_screen[i] = BLANK_CODE;
            end
        end else begin
            cur_row++;
        end
    endfunction

    function automatic void wipe_screen();
        for (int i = 0; i < CELLS; i++) begin
            shadow_screen[i] = BLANK_CODE;
        end
        cur_col = '0;
        cur_row = '0;
        toggle_cursor();
    endfunction

    function automatic t_console_status apply_console_cmd(t_console_cmd cmd);
        t_console_status status;
        status.read_data = '0;
        case (cmd.kind)
            KIND_PUT: begin
                if (cmd.char_code == NEWLINE) begin
                    toggle_cursor();
                    advance_row();
                    toggle_cursor();
                end else begin
                    // the new code also drops the cursor flip of this cell
                    shadow_screen[{cur_row, cur_col}] =
                        display_code(cmd.char_code, cmd.video_flip);
                    if (cur_col == COL_W'(COLUMNS - 1)) begin
                        advance_row();
                    end else begin
                        cur_col++;
                    end
                    toggle_cursor();
                end
            end
            KIND_CLEAR: begin
                wipe_screen();
            end
            KIND_READ: begin
                status.read_data = shadow_screen[cmd.cell_addr];
            end
            default: begin
            end
        endcase
        status.cursor_col = cur_col;
        status.cursor_row = cur_row;
        return status;
    endfunction

    // ---------------------------------------------------------------
    // Driver: item stream and result back-pressure, changed on falling edges
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            // a held item stays until taken
            if (!i_s_tvalid || cmd_taken) begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_cmd = pending_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= next_cmd.kind;
                    i_s_tdata  <= {6'b0, next_cmd.cell_addr, next_cmd.video_flip,
                                   next_cmd.char_code};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: results checked first, then accepted items predicted
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_console_status want;
        t_console_cmd    cmd;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (awaited_status.size() == 0) begin
                    $error("result with nothing expected: tdata %06h", o_m_tdata);
                    mismatch_count++;
                end else begin
                    want = awaited_status.pop_front();
                    if (o_m_tdata[7:0] !== want.read_data) begin
                        $error("read_data: expected %02h, got %02h",
                               want.read_data, o_m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[12:8] !== want.cursor_col) begin
                        $error("cursor_col: expected %0d, got %0d",
                               want.cursor_col, o_m_tdata[12:8]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[16:13] !== want.cursor_row) begin
                        $error("cursor_row: expected %0d, got %0d",
                               want.cursor_row, o_m_tdata[16:13]);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                cmd_taken      = 1'b1;
                cmd.kind       = i_s_tuser;
                cmd.char_code  = i_s_tdata[7:0];
                cmd.video_flip = i_s_tdata[8];
                cmd.cell_addr  = i_s_tdata[17:9];
                awaited_status.push_back(apply_console_cmd(cmd));
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic t_console_cmd make_cmd(logic [1:0] kind, logic [7:0] ch,
                                              logic flip, logic [8:0] addr);
        t_console_cmd cmd;
        cmd.kind       = kind;
        cmd.char_code  = ch;
        cmd.video_flip = flip;
        cmd.cell_addr  = addr;
        return cmd;
    endfunction

    // Sender holds off until every queued item has come back
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_s_tvalid || awaited_status.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Mostly lines of printable text, with read bursts, newlines and some noise
    task automatic queue_text_traffic(input int count);
        int       queued;
        int       roll;
        int       len;
        logic [7:0] ch;
        queued = 0;
        while (queued < count) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(25);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(9) == 0) begin
                        ch = 8'($urandom_range(255));
                    end else begin
                        ch = 8'($urandom_range(SHIFT_HI, KEEP_LO));
                    end
                    pending_cmds.push_back(make_cmd(KIND_PUT, ch, $urandom_range(9) != 0,
                                                    9'($urandom_range(511))));
                end
                if ($urandom_range(3) != 0) begin
                    pending_cmds.push_back(make_cmd(KIND_PUT, NEWLINE,
                                                    1'($urandom_range(1)),
                                                    9'($urandom_range(511))));
                    len++;
                end
                queued += len;
            end else if (roll < 82) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    pending_cmds.push_back(make_cmd(KIND_READ, 8'($urandom_range(255)),
                                                    1'($urandom_range(1)),
                                                    9'($urandom_range(511))));
                end
                queued += len;
            end else if (roll < 90) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    pending_cmds.push_back(make_cmd(KIND_PUT, NEWLINE,
                                                    1'($urandom_range(1)),
                                                    9'($urandom_range(511))));
                end
                queued += len;
            end else if (roll < 95) begin
                pending_cmds.push_back(make_cmd(KIND_PUT, 8'($urandom_range(255)),
                                                1'($urandom_range(1)),
                                                9'($urandom_range(511))));
                queued++;
            end else if (roll < 98) begin
                pending_cmds.push_back(make_cmd(KIND_SPARE, 8'($urandom_range(255)),
                                                1'($urandom_range(1)),
                                                9'($urandom_range(511))));
                queued++;
            end else begin
                pending_cmds.push_back(make_cmd(KIND_CLEAR, 8'($urandom_range(255)),
                                                1'($urandom_range(1)),
                                                9'($urandom_range(511))));
                queued++;
            end
        end
    endtask

    initial begin
        wipe_screen();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset screen, mapping edges with both flip settings,
        // newline, unused kind, read-back and clear
        pending_cmds.push_back(make_cmd(KIND_READ,  8'h00, 1'b0, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_READ,  8'hFF, 1'b1, 9'd511));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'h1F, 1'b1, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'h20, 1'b0, 9'd511));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'h3F, 1'b1, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'h40, 1'b0, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'h5E, 1'b1, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'h5F, 1'b0, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'hFF, 1'b1, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_PUT,   8'h00, 1'b0, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_PUT,   NEWLINE, 1'b1, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_SPARE, 8'hFF, 1'b1, 9'd511));
        pending_cmds.push_back(make_cmd(KIND_READ,  8'h00, 1'b0, 9'd0));
        pending_cmds.push_back(make_cmd(KIND_READ,  8'h00, 1'b0, 9'd32));
        pending_cmds.push_back(make_cmd(KIND_CLEAR, 8'hFF, 1'b1, 9'd511));
        pending_cmds.push_back(make_cmd(KIND_READ,  8'h00, 1'b0, 9'd0));
        wait_drained();

        queue_text_traffic(220);
        wait_drained();

        // no idling on either side for a while
        calm = 1'b1;
        queue_text_traffic(150);
        wait_drained();
        calm = 1'b0;

        queue_text_traffic(230);
        wait_drained();

        repeat (1100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("text_console_writer_test: clean");
        end else begin
            $display("text_console_writer_test: errors");
        end
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("text_console_writer_test: errors");
        $finish;
    end

endmodule
